// ===== hw/rtl/pidc_pkg.sv =====
// Constants for the clamped PID controller: widths, register indexes and reset values.
// Depends on nothing; pid_controller_clamped refers to it by scoped names.
package pidc_pkg;

   localparam int DATA_W = 32;             // Q16.16 operands
   localparam int RATE_W = 31;             // dt and 1/dt registers
   localparam int SUM_W  = 48;             // integral, Q32.16
   localparam int MUL_W  = 33;             // shared multiplier operand
   localparam int PROD_W = 2 * MUL_W;
   localparam int ACC_W  = 82;             // exact sum of the three gain products
   localparam int FRAC_W = 16;
   localparam int CSR_AW = 3;

   localparam logic [CSR_AW-1:0] CSR_GAIN_P    = 3'd0;
   localparam logic [CSR_AW-1:0] CSR_GAIN_I    = 3'd1;
   localparam logic [CSR_AW-1:0] CSR_GAIN_D    = 3'd2;
   localparam logic [CSR_AW-1:0] CSR_OUT_MIN   = 3'd3;
   localparam logic [CSR_AW-1:0] CSR_OUT_MAX   = 3'd4;
   localparam logic [CSR_AW-1:0] CSR_STEP_TIME = 3'd5;
   localparam logic [CSR_AW-1:0] CSR_STEP_RATE = 3'd6;

   localparam logic signed [DATA_W-1:0] GAIN_P_RST  = 32'sd98304;
   localparam logic signed [DATA_W-1:0] GAIN_I_RST  = 32'sd0;
   localparam logic signed [DATA_W-1:0] GAIN_D_RST  = 32'sd6554;
   localparam logic signed [DATA_W-1:0] OUT_MIN_RST = -32'sd6553600;
   localparam logic signed [DATA_W-1:0] OUT_MAX_RST = 32'sd6553600;
   localparam logic [RATE_W-1:0]        STEP_RST    = 31'd65536;

endpackage

// ===== hw/rtl/pid_controller_clamped.sv =====
// Clamped positional PID controller, signed Q16.16, one shared 33x33 multiplier.
// Each request makes seven passes through the shared multiplier (M0 to M6), then accumulate,
// round and clamp; a new request is taken only in idle, and clamp waits for a free output.
// A finished result waits in the output register while the next request is accepted.
// Reset (synchronous, active high) loads the gain, clamp and dt registers with their
// defaults and clears the integral, the last error and the output valid.
module pid_controller_clamped (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [63:0]                   req_tdata,   // setpoint [31:0], measured [63:32]
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [31:0]                   rsp_tdata,   // drive [31:0]
   input  logic                          csr_we,
   input  logic [pidc_pkg::CSR_AW-1:0]   csr_addr,
   input  logic [pidc_pkg::DATA_W-1:0]   csr_wdata
);

   typedef enum logic [3:0] {
      ST_IDLE, ST_M0, ST_M1, ST_M2, ST_M3, ST_M4, ST_M5, ST_M6, ST_ACC, ST_RND, ST_CLAMP
   } state_type;

   localparam int DW = pidc_pkg::DATA_W;
   localparam int SW = pidc_pkg::SUM_W;
   localparam int MW = pidc_pkg::MUL_W;
   localparam int PW = pidc_pkg::PROD_W;
   localparam int AW = pidc_pkg::ACC_W;
   localparam int FW = pidc_pkg::FRAC_W;
   localparam int RW = pidc_pkg::RATE_W;
   localparam int RND_W = AW - FW;

   state_type state_ff, state_in;

   logic signed [DW-1:0] gain_p_ff, gain_p_in, gain_i_ff, gain_i_in, gain_d_ff, gain_d_in;
   logic signed [DW-1:0] out_min_ff, out_min_in, out_max_ff, out_max_in;
   logic [RW-1:0]        step_time_ff, step_time_in, step_rate_ff, step_rate_in;

   logic signed [SW-1:0] error_sum_ff, error_sum_in;
   logic signed [DW-1:0] prev_error_ff, prev_error_in;
   logic signed [DW-1:0] err_ff, err_in;
   logic signed [SW-1:0] deriv_ff, deriv_in;
   logic signed [PW-1:0] prod_ff, prod_in;
   logic signed [AW-1:0] acc_ff, acc_in;
   logic signed [RND_W-1:0] rnd_ff, rnd_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [DW-1:0]        rsp_data_ff, rsp_data_in;

   logic signed [MW-1:0] mul_a, mul_b;
   logic signed [DW:0]   in_diff;
   logic signed [PW-1:0] prod_half;
   logic signed [PW-FW-1:0] prod_resc;
   logic signed [SW+2:0] sum_wide;
   logic signed [AW-1:0] prod_ext, prod_sh, acc_half;
   logic signed [RND_W-1:0] min_ext, max_ext, clamp_lo, clamp_hi;
   logic                 req_fire, out_free;

   assign req_tready = (state_ff == ST_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // operand select for the shared multiplier
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (state_ff)
         ST_M0: begin
            mul_a = MW'(err_ff);
            mul_b = signed'({2'b00, step_time_ff});
         end
         ST_M1: begin
            mul_a = MW'(err_ff) - MW'(prev_error_ff);
            mul_b = signed'({2'b00, step_rate_ff});
         end
         ST_M2: begin
            mul_a = MW'(gain_p_ff);
            mul_b = MW'(err_ff);
         end
         ST_M3: begin
            mul_a = MW'(gain_i_ff);
            mul_b = signed'({17'd0, error_sum_ff[FW-1:0]});
         end
         ST_M4: begin
            mul_a = MW'(gain_i_ff);
            mul_b = MW'(signed'(error_sum_ff[SW-1:FW]));
         end
         ST_M5: begin
            mul_a = MW'(gain_d_ff);
            mul_b = signed'({17'd0, deriv_ff[FW-1:0]});
         end
         ST_M6: begin
            mul_a = MW'(gain_d_ff);
            mul_b = MW'(signed'(deriv_ff[SW-1:FW]));
         end
         default: begin
         end
      endcase
   end

   assign prod_in   = mul_a * mul_b;
   assign in_diff   = (DW+1)'(signed'(req_tdata[31:0])) - (DW+1)'(signed'(req_tdata[63:32]));
   // round to nearest, ties up: add half an lsb, then arithmetic shift
   assign prod_half = prod_ff + PW'(32768);
   assign prod_resc = prod_half[PW-1:FW];
   assign sum_wide  = (SW+3)'(error_sum_ff) + (SW+3)'(prod_resc);
   assign prod_ext  = AW'(prod_ff);
   assign prod_sh   = AW'({prod_ff, 16'h0000});
   assign acc_half  = acc_ff + AW'(32768);
   assign min_ext   = RND_W'(out_min_ff);
   assign max_ext   = RND_W'(out_max_ff);
   assign clamp_lo  = (rnd_ff < min_ext) ? min_ext : rnd_ff;
   assign clamp_hi  = (clamp_lo > max_ext) ? max_ext : clamp_lo;

   always_comb begin
      state_in      = state_ff;
      gain_p_in     = gain_p_ff;
      gain_i_in     = gain_i_ff;
      gain_d_in     = gain_d_ff;
      out_min_in    = out_min_ff;
      out_max_in    = out_max_ff;
      step_time_in  = step_time_ff;
      step_rate_in  = step_rate_ff;
      error_sum_in  = error_sum_ff;
      prev_error_in = prev_error_ff;
      err_in        = err_ff;
      deriv_in      = deriv_ff;
      acc_in        = acc_ff;
      rnd_in        = rnd_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_data_in   = rsp_data_ff;

      if (csr_we) begin
         unique case (csr_addr)
            pidc_pkg::CSR_GAIN_P:    gain_p_in    = signed'(csr_wdata);
            pidc_pkg::CSR_GAIN_I:    gain_i_in    = signed'(csr_wdata);
            pidc_pkg::CSR_GAIN_D:    gain_d_in    = signed'(csr_wdata);
            pidc_pkg::CSR_OUT_MIN:   out_min_in   = signed'(csr_wdata);
            pidc_pkg::CSR_OUT_MAX:   out_max_in   = signed'(csr_wdata);
            pidc_pkg::CSR_STEP_TIME: step_time_in = csr_wdata[RW-1:0];
            pidc_pkg::CSR_STEP_RATE: step_rate_in = csr_wdata[RW-1:0];
            default: begin
            end
         endcase
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               if (in_diff[DW] != in_diff[DW-1])
                  err_in = in_diff[DW] ? signed'({1'b1, {(DW-1){1'b0}}})
                                       : signed'({1'b0, {(DW-1){1'b1}}});
               else
                  err_in = in_diff[DW-1:0];
               state_in = ST_M0;
            end
         end
         ST_M0: state_in = ST_M1;
         ST_M1: begin
            // integral update from err * dt, saturated to 48 bits
            if (sum_wide[SW+2:SW-1] != {4{sum_wide[SW+2]}})
               error_sum_in = sum_wide[SW+2] ? signed'({1'b1, {(SW-1){1'b0}}})
                                             : signed'({1'b0, {(SW-1){1'b1}}});
            else
               error_sum_in = sum_wide[SW-1:0];
            state_in = ST_M2;
         end
         ST_M2: begin
            deriv_in = prod_resc[SW-1:0];
            state_in = ST_M3;
         end
         ST_M3: begin
            acc_in   = prod_ext;
            state_in = ST_M4;
         end
         ST_M4: begin
            acc_in   = acc_ff + prod_ext;
            state_in = ST_M5;
         end
         ST_M5: begin
            acc_in   = acc_ff + prod_sh;
            state_in = ST_M6;
         end
         ST_M6: begin
            acc_in   = acc_ff + prod_ext;
            state_in = ST_ACC;
         end
         ST_ACC: begin
            acc_in   = acc_ff + prod_sh;
            state_in = ST_RND;
         end
         ST_RND: begin
            rnd_in        = acc_half[AW-1:FW];
            prev_error_in = err_ff;
            state_in      = ST_CLAMP;
         end
         ST_CLAMP: begin
            // lower clamp first, upper last
            if (out_free) begin
               rsp_data_in  = clamp_hi[DW-1:0];
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      prod_ff     <= prod_in;
      err_ff      <= err_in;
      deriv_ff    <= deriv_in;
      acc_ff      <= acc_in;
      rnd_ff      <= rnd_in;
      rsp_data_ff <= rsp_data_in;
      if (reset) begin
         state_ff      <= ST_IDLE;
         gain_p_ff     <= pidc_pkg::GAIN_P_RST;
         gain_i_ff     <= pidc_pkg::GAIN_I_RST;
         gain_d_ff     <= pidc_pkg::GAIN_D_RST;
         out_min_ff    <= pidc_pkg::OUT_MIN_RST;
         out_max_ff    <= pidc_pkg::OUT_MAX_RST;
         step_time_ff  <= pidc_pkg::STEP_RST;
         step_rate_ff  <= pidc_pkg::STEP_RST;
         error_sum_ff  <= '0;
         prev_error_ff <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         gain_p_ff     <= gain_p_in;
         gain_i_ff     <= gain_i_in;
         gain_d_ff     <= gain_d_in;
         out_min_ff    <= out_min_in;
         out_max_ff    <= out_max_in;
         step_time_ff  <= step_time_in;
         step_rate_ff  <= step_rate_in;
         error_sum_ff  <= error_sum_in;
         prev_error_ff <= prev_error_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   a_reset_clears: assert property (@(posedge clock)
      $past(reset) |-> (state_ff == ST_IDLE) && !rsp_valid_ff)
      else $error("state not cleared after reset");

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> (state_ff == ST_M0) && !req_tready)
      else $error("request accepted but sequencer did not start");

   a_clamp_loads: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CLAMP) && out_free |=> rsp_valid_ff && (state_ff == ST_IDLE))
      else $error("clamp stage did not deliver result");

   a_prev_hold: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_RND) |=> $stable(prev_error_ff))
      else $error("last error changed outside round stage");

   a_sum_hold: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_M1) |=> $stable(error_sum_ff))
      else $error("integral changed outside its update stage");

endmodule
